// File: design/tpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_pkg
// Shared constants, widths and the C0 note table of the note quantiser.
// ----------------------------------------------------------------------------
package tpn_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int NUM_OCTAVES  = 8;
    localparam int NUM_KEYS     = 68;

    localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int OCT_W      = (NUM_OCTAVES > 1) ? $clog2(NUM_OCTAVES) : 1;
    localparam int NOTE_W     = 4;
    localparam int KEY_W      = 7;
    localparam int NOTES      = 12;
    localparam int CLK_W      = 24;
    localparam int PERIOD_W   = 11;

    // freq = clock * 16 / (period + 1) for pulse, clock * 8 / (period + 1) for triangle
    localparam int DIVIDEND_W = CLK_W + 4;
    localparam int DIVISOR_W  = PERIOD_W + 1;
    localparam int FREQ_W     = DIVIDEND_W;
    localparam int DCNT_W     = $clog2(DIVIDEND_W);

    localparam int C0_W       = 13;
    localparam int CMP_W      = C0_W + NUM_OCTAVES - 1;
    localparam int WIDE_W     = (FREQ_W > CMP_W) ? FREQ_W : CMP_W;
    localparam int BEST_W     = 20;

    localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(1789773);
    localparam logic [BEST_W-1:0] DIST_LIMIT  = BEST_W'(1000000);
    localparam logic [KEY_W-1:0]  FIRST_KEY   = KEY_W'(21);
    localparam logic [KEY_W-1:0]  LAST_KEY    = KEY_W'(21 + NUM_KEYS - 1);
    localparam logic [NOTES-1:0]  SHARP_MASK  = 12'h54A;

    localparam logic [2:0] CH_TRIANGLE  = 3'd2;
    localparam logic [2:0] CH_LAST_TONE = 3'd2;

    localparam logic [OCT_W-1:0]  OCT_LAST  = OCT_W'(NUM_OCTAVES - 1);
    localparam logic [NOTE_W-1:0] NOTE_LAST = NOTE_W'(NOTES - 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [C0_W-1:0] c0_freq(input logic [NOTE_W-1:0] n);
        logic [C0_W-1:0] f;
        unique case (n)
            4'd0:    f = 13'd4186;
            4'd1:    f = 13'd4434;
            4'd2:    f = 13'd4698;
            4'd3:    f = 13'd4978;
            4'd4:    f = 13'd5274;
            4'd5:    f = 13'd5587;
            4'd6:    f = 13'd5919;
            4'd7:    f = 13'd6271;
            4'd8:    f = 13'd6644;
            4'd9:    f = 13'd7040;
            4'd10:   f = 13'd7458;
            4'd11:   f = 13'd7902;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: design/tpn_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_req_if
// Request channel: one channel's activity flag and tone timer period.
// ----------------------------------------------------------------------------
interface tpn_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic        active;
    logic [10:0] timer_period;

    modport source (output valid, output channel, output active, output timer_period,
                    input ready);
    modport sink   (input valid, input channel, input active, input timer_period,
                    output ready);
endinterface

// File: design/tpn_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_res_if
// Result channel: released key, lit key and nearest note of one request.
// ----------------------------------------------------------------------------
interface tpn_res_if;
    logic       valid;
    logic       ready;
    logic       cleared_valid;
    logic [6:0] cleared_key;
    logic       cleared_sharp;
    logic       lit_valid;
    logic [6:0] lit_key;
    logic       lit_sharp;
    logic       match_found;
    logic [3:0] note;
    logic [2:0] octave;

    modport source (output valid, output cleared_valid, output cleared_key,
                    output cleared_sharp, output lit_valid, output lit_key,
                    output lit_sharp, output match_found, output note, output octave,
                    input ready);
    modport sink   (input valid, input cleared_valid, input cleared_key,
                    input cleared_sharp, input lit_valid, input lit_key,
                    input lit_sharp, input match_found, input note, input octave,
                    output ready);
endinterface

// File: design/timer_period_to_nearest_note_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_period_to_nearest_note_core
// Maps a channel's tone timer period to the nearest semitone key.
// ----------------------------------------------------------------------------
// Requests arrive on req (channel, active, timer_period) and each yields one
// result on rsp: the key the channel released, the key it lights and the
// nearest note and octave. cfg_wr_en / cfg_wr_data load the source clock in
// hertz; write it only while the block is idle.
// A sounding tone channel with a nonzero frequency runs the serial divider
// (one quotient bit a cycle), takes the quotient, searches all 96 note table
// entries (one a cycle through one subtract and compare) and loads the result.
// A new request is taken only after the result is loaded.
// A zero frequency skips the search and loads its result after the divider.
// Noise, sample, inactive and unknown channels skip the divider and the search
// and go straight from idle to the result load.
// req.ready is high only while no request is in progress.
// The result sits in an output register: a stalled receiver lets the next
// request be accepted and worked, and its result waits until the register
// frees.
// Reset clears every channel's lit key, sets the clock to 1789773 Hz and
// empties the output register.
// ----------------------------------------------------------------------------
module timer_period_to_nearest_note_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tpn_pkg::CLK_W-1:0]   cfg_wr_data,
    tpn_req_if.sink                     req,
    tpn_res_if.source                   rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SRCH = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                          state_reg;
    logic [tpn_pkg::CLK_W-1:0]       clk_hz_reg;

    logic                            lit_vld_reg [tpn_pkg::NUM_CHANNELS];
    logic [tpn_pkg::KEY_W-1:0]       lit_idx_reg [tpn_pkg::NUM_CHANNELS];
    logic                            lit_shp_reg [tpn_pkg::NUM_CHANNELS];

    logic [tpn_pkg::CH_W-1:0]        ch_reg;
    logic                            upd_reg;
    logic                            clr_vld_reg;
    logic [tpn_pkg::KEY_W-1:0]       clr_key_reg;
    logic                            clr_shp_reg;

    logic [tpn_pkg::FREQ_W-1:0]      freq_reg;
    logic [tpn_pkg::BEST_W-1:0]      best_reg;
    logic                            found_reg;
    logic [tpn_pkg::OCT_W-1:0]       oct_reg, bo_reg;
    logic [tpn_pkg::NOTE_W-1:0]      note_reg, bn_reg;

    logic                            out_vld_reg;
    logic                            out_clr_vld_reg, out_clr_shp_reg;
    logic [tpn_pkg::KEY_W-1:0]       out_clr_key_reg;
    logic                            out_lit_vld_reg, out_lit_shp_reg;
    logic [tpn_pkg::KEY_W-1:0]       out_lit_key_reg;
    logic                            out_match_reg;
    logic [tpn_pkg::NOTE_W-1:0]      out_note_reg;
    logic [2:0]                      out_oct_reg;

    logic                            accept, chan_ok, has_src, div_start;
    logic [tpn_pkg::CH_W-1:0]        ch_in;
    logic [tpn_pkg::DIVIDEND_W-1:0]  dividend;
    logic [tpn_pkg::DIVISOR_W-1:0]   divisor;
    tpn_pkg::div_stat_t              div_stat;
    logic [tpn_pkg::DIVIDEND_W-1:0]  quotient;

    logic [tpn_pkg::WIDE_W-1:0]      cmp, freq_w, gap;
    logic                            better, last_entry;
    logic [tpn_pkg::KEY_W-1:0]       key, lit_idx;
    logic                            lit_now, lit_shp, out_free;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign chan_ok   = (32'(req.channel) < tpn_pkg::NUM_CHANNELS);
    assign has_src   = chan_ok && req.active && (req.channel <= tpn_pkg::CH_LAST_TONE);
    assign ch_in     = tpn_pkg::CH_W'(req.channel);
    assign div_start = accept && has_src;
    assign dividend  = (req.channel == tpn_pkg::CH_TRIANGLE)
                       ? (tpn_pkg::DIVIDEND_W'(clk_hz_reg) << 3)
                       : (tpn_pkg::DIVIDEND_W'(clk_hz_reg) << 4);
    assign divisor   = tpn_pkg::DIVISOR_W'(req.timer_period) + 1'b1;

    tpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // search datapath: one table entry a cycle
    assign cmp        = tpn_pkg::WIDE_W'(tpn_pkg::c0_freq(note_reg)) << oct_reg;
    assign freq_w     = tpn_pkg::WIDE_W'(freq_reg);
    assign gap        = (cmp > freq_w) ? (cmp - freq_w) : (freq_w - cmp);
    assign better     = (gap < tpn_pkg::WIDE_W'(best_reg));
    assign last_entry = (oct_reg == tpn_pkg::OCT_LAST) && (note_reg == tpn_pkg::NOTE_LAST);

    assign key      = tpn_pkg::KEY_W'(bo_reg) * tpn_pkg::KEY_W'(12)
                      + tpn_pkg::KEY_W'(bn_reg);
    assign lit_now  = found_reg && (key >= tpn_pkg::FIRST_KEY) && (key <= tpn_pkg::LAST_KEY);
    assign lit_idx  = key - tpn_pkg::FIRST_KEY;
    assign lit_shp  = tpn_pkg::SHARP_MASK[bn_reg];
    assign out_free = !out_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= tpn_pkg::CLOCK_RESET;
        end
        else if (cfg_wr_en)
        begin
            clk_hz_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < tpn_pkg::NUM_CHANNELS; i++)
            begin
                lit_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (out_vld_reg && rsp.ready && (state_reg != S_FIN))
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= has_src ? S_DIV : S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= (quotient == '0) ? S_FIN : S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (last_entry)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (upd_reg)
                        begin
                            lit_vld_reg[ch_reg] <= lit_now;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                ch_reg    <= ch_in;
                upd_reg   <= chan_ok;
                found_reg <= 1'b0;
                bo_reg    <= '0;
                bn_reg    <= '0;
                if (chan_ok && lit_vld_reg[ch_in])
                begin
                    clr_vld_reg <= 1'b1;
                    clr_key_reg <= lit_idx_reg[ch_in];
                    clr_shp_reg <= lit_shp_reg[ch_in];
                end
                else
                begin
                    clr_vld_reg <= 1'b0;
                    clr_key_reg <= '0;
                    clr_shp_reg <= 1'b0;
                end
            end
            S_DIV:
            begin
                freq_reg <= quotient;
                best_reg <= tpn_pkg::DIST_LIMIT;
                oct_reg  <= '0;
                note_reg <= '0;
            end
            S_SRCH:
            begin
                if (better)
                begin
                    best_reg  <= gap[tpn_pkg::BEST_W-1:0];
                    found_reg <= 1'b1;
                    bo_reg    <= oct_reg;
                    bn_reg    <= note_reg;
                end
                if (note_reg == tpn_pkg::NOTE_LAST)
                begin
                    note_reg <= '0;
                    oct_reg  <= oct_reg + 1'b1;
                end
                else
                begin
                    note_reg <= note_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_clr_vld_reg <= clr_vld_reg;
                    out_clr_key_reg <= clr_key_reg;
                    out_clr_shp_reg <= clr_shp_reg;
                    out_lit_vld_reg <= lit_now;
                    out_lit_key_reg <= lit_now ? lit_idx : '0;
                    out_lit_shp_reg <= lit_now && lit_shp;
                    out_match_reg   <= found_reg;
                    out_note_reg    <= bn_reg;
                    out_oct_reg     <= 3'(bo_reg);
                    if (upd_reg)
                    begin
                        lit_idx_reg[ch_reg] <= lit_idx;
                        lit_shp_reg[ch_reg] <= lit_shp;
                    end
                end
            end
            default:
            begin
                upd_reg <= 1'b0;
            end
        endcase
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.cleared_valid = out_clr_vld_reg;
    assign rsp.cleared_key   = out_clr_key_reg;
    assign rsp.cleared_sharp = out_clr_shp_reg;
    assign rsp.lit_valid     = out_lit_vld_reg;
    assign rsp.lit_key       = out_lit_key_reg;
    assign rsp.lit_sharp     = out_lit_shp_reg;
    assign rsp.match_found   = out_match_reg;
    assign rsp.note          = out_note_reg;
    assign rsp.octave        = out_oct_reg;

endmodule

// File: design/tpn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module tpn_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tpn_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [tpn_pkg::DIVISOR_W-1:0]    divisor,
    output tpn_pkg::div_stat_t               stat,
    output logic [tpn_pkg::DIVIDEND_W-1:0]   quotient
);

    logic [tpn_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [tpn_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [tpn_pkg::DIVISOR_W-1:0]  den_reg;
    logic [tpn_pkg::DCNT_W-1:0]     cnt_reg;
    logic                           busy_reg, done_reg;
    logic [tpn_pkg::DIVISOR_W:0]    trial, diff;
    logic                           ge;

    assign trial = {rem_reg, quo_reg[tpn_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next = ge ? diff[tpn_pkg::DIVISOR_W-1:0] : trial[tpn_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[tpn_pkg::DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tpn_pkg::DCNT_W'(tpn_pkg::DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: design/tpn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_checker
// Port-level checks of the note quantiser, bound to the top level.
// ----------------------------------------------------------------------------
module tpn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       cleared_valid,
    input logic [6:0] cleared_key,
    input logic       cleared_sharp,
    input logic       lit_valid,
    input logic [6:0] lit_key,
    input logic       lit_sharp,
    input logic       match_found,
    input logic [3:0] note,
    input logic [2:0] octave
);

    // hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // one request in progress at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a lit key matches the reported note and octave
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && lit_valid |->
            match_found && (8'(lit_key) + 8'd21 == 8'(octave) * 8'd12 + 8'(note)))
        else $error("lit key inconsistent with note");

    // fields without meaning stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            (cleared_valid || (cleared_key == 7'd0 && !cleared_sharp)) &&
            (lit_valid || (lit_key == 7'd0 && !lit_sharp)))
        else $error("unused key fields not zero");

    // no match reports note and octave zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !match_found |-> note == 4'd0 && octave == 3'd0 && !lit_valid)
        else $error("no match with nonzero note");

endmodule

bind timer_period_to_nearest_note_core tpn_checker u_tpn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .cleared_valid (rsp.cleared_valid),
    .cleared_key   (rsp.cleared_key),
    .cleared_sharp (rsp.cleared_sharp),
    .lit_valid     (rsp.lit_valid),
    .lit_key       (rsp.lit_key),
    .lit_sharp     (rsp.lit_sharp),
    .match_found   (rsp.match_found),
    .note          (rsp.note),
    .octave        (rsp.octave)
);

// File: tb/tpn_key_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpn_key_checker
// Watches the request, result and clock-register ports of the note quantiser,
// predicts each result from its own copy of the clock register and of every
// channel's lit key, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module tpn_key_checker
    import tpn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data,
    tpn_req_if               req,
    tpn_res_if               rsp,
    output int unsigned      mismatch_count,
    output int unsigned      awaited_count,
    output int unsigned      result_count,
    output int unsigned      lit_count,
    output int unsigned      cleared_count
);

    typedef struct packed {
        logic       cleared_valid;
        logic [6:0] cleared_key;
        logic       cleared_sharp;
        logic       lit_valid;
        logic [6:0] lit_key;
        logic       lit_sharp;
        logic       match_found;
        logic [3:0] note;
        logic [2:0] octave;
    } key_event_t;

    logic [12:0]      c0_tone [12];
    logic [CLK_W-1:0] clock_hz;
    logic [KEY_W-1:0] lit_key_mem [NUM_CHANNELS];
    key_event_t       expected_events [$];

    initial
    begin
        c0_tone = '{13'd4186, 13'd4434, 13'd4698, 13'd4978, 13'd5274, 13'd5587,
                    13'd5919, 13'd6271, 13'd6644, 13'd7040, 13'd7458, 13'd7902};
    end

    function automatic key_event_t predict_key_event(input logic [2:0] ch,
                                                     input logic act,
                                                     input logic [10:0] per);
        key_event_t  ev;
        logic [63:0] freq;
        logic [63:0] tone;
        logic [63:0] spread;
        logic [63:0] best;
        logic [6:0]  key;
        logic        found;
        ev    = '0;
        freq  = '0;
        best  = 64'(DIST_LIMIT);
        found = 1'b0;
        if (int'(ch) >= NUM_CHANNELS)
            return ev;
        if (act && ch <= CH_LAST_TONE)
            freq = (64'(clock_hz) * ((ch == CH_TRIANGLE) ? 64'd128 : 64'd256))
                   / (64'd16 * (64'(per) + 64'd1));
        if (lit_key_mem[ch] != '0)
        begin
            ev.cleared_valid = 1'b1;
            ev.cleared_key   = lit_key_mem[ch] - FIRST_KEY;
            ev.cleared_sharp = SHARP_MASK[lit_key_mem[ch] % 12];
            lit_key_mem[ch]  = '0;
        end
        if (freq != '0)
        begin
            for (int o = 0; o < NUM_OCTAVES; o++)
            begin
                for (int n = 0; n < 12; n++)
                begin
                    tone   = 64'(c0_tone[n]) << o;
                    spread = (tone > freq) ? tone - freq : freq - tone;
                    if (spread < best)
                    begin
                        best      = spread;
                        found     = 1'b1;
                        ev.note   = 4'(n);
                        ev.octave = 3'(o);
                    end
                end
            end
            if (found)
            begin
                ev.match_found = 1'b1;
                key = 7'(int'(ev.octave) * 12 + int'(ev.note));
                if (key >= FIRST_KEY && key <= LAST_KEY)
                begin
                    ev.lit_valid    = 1'b1;
                    ev.lit_key      = key - FIRST_KEY;
                    ev.lit_sharp    = SHARP_MASK[key % 12];
                    lit_key_mem[ch] = key;
                end
            end
        end
        return ev;
    endfunction

    task automatic check_field(input string name, input logic [6:0] want,
                               input logic [6:0] got, inout bit bad);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        key_event_t want;
        key_event_t got;
        bit         bad;
        if (!rst_n)
        begin
            clock_hz = CLOCK_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++)
                lit_key_mem[i] = '0;
            expected_events.delete();
        end
        else
        begin
            if (cfg_wr_en)
                clock_hz = cfg_wr_data;
            if (req.valid && req.ready)
                expected_events.push_back(predict_key_event(req.channel, req.active,
                                                            req.timer_period));
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (expected_events.size() == 0)
                begin
                    $display("%0t ns: result arrived with no request awaiting it", $time);
                    mismatch_count++;
                end
                else
                begin
                    want              = expected_events.pop_front();
                    got.cleared_valid = rsp.cleared_valid;
                    got.cleared_key   = rsp.cleared_key;
                    got.cleared_sharp = rsp.cleared_sharp;
                    got.lit_valid     = rsp.lit_valid;
                    got.lit_key       = rsp.lit_key;
                    got.lit_sharp     = rsp.lit_sharp;
                    got.match_found   = rsp.match_found;
                    got.note          = rsp.note;
                    got.octave        = rsp.octave;
                    bad = 1'b0;
                    check_field("cleared_valid", 7'(want.cleared_valid),
                                7'(got.cleared_valid), bad);
                    check_field("cleared_key", want.cleared_key, got.cleared_key, bad);
                    check_field("cleared_sharp", 7'(want.cleared_sharp),
                                7'(got.cleared_sharp), bad);
                    check_field("lit_valid", 7'(want.lit_valid), 7'(got.lit_valid), bad);
                    check_field("lit_key", want.lit_key, got.lit_key, bad);
                    check_field("lit_sharp", 7'(want.lit_sharp), 7'(got.lit_sharp), bad);
                    check_field("match_found", 7'(want.match_found),
                                7'(got.match_found), bad);
                    check_field("note", 7'(want.note), 7'(got.note), bad);
                    check_field("octave", 7'(want.octave), 7'(got.octave), bad);
                    if (bad)
                        mismatch_count++;
                    if (want.lit_valid)
                        lit_count++;
                    if (want.cleared_valid)
                        cleared_count++;
                end
            end
        end
        awaited_count = expected_events.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the note quantiser with directed and random channel requests across
// several source clock settings, with bursty sending and a stalling receiver,
// and reports the verdict from the checker's mismatch and awaited counts.
// ----------------------------------------------------------------------------
module tb_top;
    import tpn_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned LONG_HOLD   = 1200;
    localparam logic [2:0]  CH_PULSE_A  = 3'd0;
    localparam logic [2:0]  CH_PULSE_B  = 3'd1;
    localparam logic [2:0]  CH_NOISE    = 3'd3;
    localparam logic [2:0]  CH_SAMPLE   = 3'd4;
    localparam logic [2:0]  CH_UNUSED   = 3'd7;

    typedef enum int {SINK_STEADY, SINK_JITTER, SINK_BURSTY} sink_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CLK_W-1:0] cfg_wr_data;
    logic [10:0]      last_period;
    int unsigned      mismatch_count;
    int unsigned      awaited_count;
    int unsigned      result_count;
    int unsigned      lit_count;
    int unsigned      cleared_count;
    int unsigned      requests_sent;
    int unsigned      clock_settings;
    int unsigned      quiet_cycles;

    tpn_req_if req_ch ();
    tpn_res_if rsp_ch ();

    timer_period_to_nearest_note_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    tpn_key_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count),
        .result_count   (result_count),
        .lit_count      (lit_count),
        .cleared_count  (cleared_count)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic idle_req(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            req_ch.valid        <= 1'b0;
            req_ch.channel      <= 3'($urandom);
            req_ch.active       <= 1'($urandom);
            req_ch.timer_period <= 11'($urandom);
        end
    endtask

    task automatic send_req(input logic [2:0] ch, input logic act, input logic [10:0] per);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.channel      <= ch;
        req_ch.active       <= act;
        req_ch.timer_period <= per;
        last_period = per;
        requests_sent++;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    task automatic drain_results();
        while (awaited_count != 0)
            idle_req(1);
        idle_req(8);
    endtask

    task automatic set_clock(input logic [CLK_W-1:0] hz);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hz;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        clock_settings++;
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [2:0]  ch;
        logic [10:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            ch = CH_PULSE_A;
        else if (pick < 54)
            ch = CH_PULSE_B;
        else if (pick < 80)
            ch = CH_TRIANGLE;
        else if (pick < 88)
            ch = CH_NOISE;
        else if (pick < 94)
            ch = CH_SAMPLE;
        else
            ch = 3'($urandom_range(NUM_CHANNELS, CH_UNUSED));
        pick = $urandom_range(0, 9);
        if (pick < 2)
            per = last_period;
        else if (pick < 4)
            per = 11'($urandom_range(0, 63));
        else
            per = 11'($urandom);
        send_req(ch, $urandom_range(0, 7) != 0, per);
    endtask

    task automatic random_requests(input int unsigned n);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send_random();
                sent++;
            end
            idle_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned mode_left;
        int unsigned holds_done;
        sink_mode_t  mode;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        mode_left    = 0;
        holds_done   = 0;
        mode         = SINK_STEADY;
        forever
        begin
            @(negedge clk);
            // hold off long enough for the block to fill and stall its input
            if ((holds_done == 0 && result_count >= 50) ||
                (holds_done == 1 && result_count >= 300))
            begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_STEADY: rsp_ch.ready <= 1'b1;
                    SINK_JITTER: rsp_ch.ready <= 1'($urandom);
                    default:
                    begin
                        if ($urandom_range(0, 15) == 0)
                        begin
                            stall_left = $urandom_range(5, 40);
                            rsp_ch.ready <= 1'b0;
                        end
                        else
                            rsp_ch.ready <= 1'b1;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t ns: nothing moved for %0d cycles", $time, QUIET_LIMIT);
            $display("** timer_period_to_nearest_note_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.channel      = '0;
        req_ch.active       = 1'b0;
        req_ch.timer_period = '0;
        last_period         = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset clock: extremes, same key twice, out-of-range keys, idle channels
        send_req(CH_PULSE_A, 1'b1, 11'd0);
        send_req(CH_PULSE_A, 1'b1, 11'd2047);
        send_req(CH_PULSE_B, 1'b1, 11'd253);
        send_req(CH_PULSE_B, 1'b1, 11'd253);
        send_req(CH_PULSE_B, 1'b0, 11'd253);
        send_req(CH_TRIANGLE, 1'b1, 11'd0);
        send_req(CH_TRIANGLE, 1'b1, 11'd2047);
        send_req(CH_TRIANGLE, 1'b1, 11'd200);
        send_req(CH_PULSE_A, 1'b1, 11'd20);
        send_req(CH_PULSE_A, 1'b1, 11'd60);
        send_req(CH_PULSE_A, 1'b1, 11'd40);
        send_req(CH_PULSE_A, 1'b1, 11'd41);
        send_req(CH_NOISE, 1'b1, 11'd100);
        send_req(CH_SAMPLE, 1'b1, 11'd100);
        send_req(3'(NUM_CHANNELS), 1'b1, 11'd253);
        send_req(CH_UNUSED, 1'b1, 11'd253);
        send_req(CH_TRIANGLE, 1'b0, 11'd2047);
        send_req(CH_PULSE_A, 1'b0, 11'd0);
        random_requests(80);

        // exact ties between neighbouring notes
        set_clock(24'd4310);
        send_req(CH_PULSE_A, 1'b1, 11'd15);
        send_req(CH_TRIANGLE, 1'b1, 11'd7);

        // distance exactly at the limit, then inside it
        set_clock(24'd125716);
        send_req(CH_PULSE_B, 1'b1, 11'd0);
        send_req(CH_PULSE_B, 1'b1, 11'd1);

        set_clock(24'd1);
        send_req(CH_PULSE_A, 1'b1, 11'd0);
        send_req(CH_PULSE_A, 1'b1, 11'd2047);
        random_requests(40);

        set_clock(24'hFFFFFF);
        send_req(CH_PULSE_B, 1'b1, 11'd0);
        random_requests(80);

        set_clock(CLK_W'($urandom_range(1, 24'hFFFFFF)));
        random_requests(80);

        set_clock(CLK_W'($urandom_range(100000, 4000000)));
        random_requests(80);

        set_clock(CLOCK_RESET);
        random_requests(80);

        drain_results();
        idle_req(24);
        $display("Run covered %0d requests and %0d results over %0d clock settings.",
                 requests_sent, result_count, clock_settings + 1);
        $display("Keys lit: %0d, keys released: %0d.", lit_count, cleared_count);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("** timer_period_to_nearest_note_core: PASSED **");
        else
            $display("** timer_period_to_nearest_note_core: FAILED **");
        $finish;
    end

endmodule
